FILE: rtl/xml_element_splitter_unit_defines.svh
// ----------------------------------------------------------------------------
// XML element splitter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef XML_ELEMENT_SPLITTER_UNIT_DEFINES_SVH
`define XML_ELEMENT_SPLITTER_UNIT_DEFINES_SVH

// same-cycle implication
`define XES_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XES_ASSERT_NX(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/xes_pkg.sv
// ----------------------------------------------------------------------------
// XML element splitter package
// Lexer state codes, character constants and default parameters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xes_pkg;

  localparam int unsigned MaxNestDefault = 255;
  localparam int unsigned ByteW          = 8;
  localparam int unsigned SplitW         = 8;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic [3:0] {
    LxText   = 4'd0,
    LxOpen   = 4'd1,
    LxTag    = 4'd2,
    LxEndTag = 4'd3,
    LxSlash  = 4'd4,
    LxCmt    = 4'd5,
    LxCmtD1  = 4'd6,
    LxCmtD2  = 4'd7,
    LxPi     = 4'd8,
    LxPiQ    = 4'd9,
    LxQuot   = 4'd10,
    LxQesc   = 4'd11
  } lex_state_e;

  localparam byte_t ChLt     = 8'h3C; // <
  localparam byte_t ChGt     = 8'h3E; // >
  localparam byte_t ChQmark  = 8'h3F; // ?
  localparam byte_t ChBang   = 8'h21; // !
  localparam byte_t ChSlash  = 8'h2F; // /
  localparam byte_t ChDquote = 8'h22; // "
  localparam byte_t ChSquote = 8'h27; // '
  localparam byte_t ChDash   = 8'h2D; // -
  localparam byte_t ChBslash = 8'h5C; // backslash

endpackage

`default_nettype wire

FILE: rtl/xml_element_splitter_unit.sv
// ----------------------------------------------------------------------------
// XML element splitter unit
// Passes XML bytes through and marks record start and end bytes.
// ----------------------------------------------------------------------------
// Pipeline: the input register loads at the input transaction, then the lexer
//   update and marks are registered into the result register.
// Throughput: one byte per cycle while the result channel is not stalled.
// Reset: lexer to text, nest level 0, double quote active, split_depth 0,
//   both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module xml_element_splitter_unit #(
  parameter int unsigned MaxNest = xes_pkg::MaxNestDefault
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output      logic                       cfg_ready_o,
  input  wire logic [xes_pkg::SplitW-1:0] split_depth_i,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [xes_pkg::ByteW-1:0]  byte_in_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_ready_i,
  output      logic [xes_pkg::ByteW-1:0]  byte_out_o,
  output      logic                       start_mark_o,
  output      logic                       end_mark_o,
  output      logic                       depth_fault_o
);
  import xes_pkg::*;

  localparam int unsigned NestW = $clog2(MaxNest + 1);
  localparam int unsigned CmpW  = (NestW > SplitW) ? NestW : SplitW;
  localparam logic [NestW-1:0] NestMax = NestW'(MaxNest);

  logic [SplitW-1:0] split_q;

  logic              s1_valid_q;
  byte_t             s1_byte_q;
  logic              s1_adv;

  lex_state_e        lex_q, lex_d;
  logic [NestW-1:0]  nest_q, nest_d, nest_dec;
  logic              qsingle_q, qsingle_d;

  logic              out_valid_q;
  byte_t             out_byte_q;
  logic              smark_q, emark_q, fault_q;
  logic              smark_d, emark_d, fault_d;
  logic              out_free;
  byte_t             qch;
  logic              cur_eq, dec_eq;

  // Config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= '0;
    end else if (cfg_valid_i) begin
      split_q <= split_depth_i;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= byte_in_i;
    end
  end

  assign qch      = qsingle_q ? ChSquote : ChDquote;
  assign nest_dec = (nest_q == '0) ? '0 : nest_q - NestW'(1);
  assign cur_eq   = CmpW'(nest_q) == CmpW'(split_q);
  assign dec_eq   = CmpW'(nest_dec) == CmpW'(split_q);

  // Next lexer state
  always_comb begin
    lex_d     = lex_q;
    nest_d    = nest_q;
    qsingle_d = qsingle_q;
    case (lex_q)
      LxText: begin
        if (s1_byte_q == ChLt) lex_d = LxOpen;
      end
      LxOpen: begin
        if (s1_byte_q == ChQmark)      lex_d = LxPi;
        else if (s1_byte_q == ChBang)  lex_d = LxCmt;
        else if (s1_byte_q == ChSlash) lex_d = LxEndTag;
        else                           lex_d = LxTag;
      end
      LxTag: begin
        if (s1_byte_q == ChGt) begin
          lex_d  = LxText;
          nest_d = (nest_q >= NestMax) ? NestMax : nest_q + NestW'(1);
        end else if (s1_byte_q == ChDquote) begin
          lex_d     = LxQuot;
          qsingle_d = 1'b0;
        end else if (s1_byte_q == ChSquote) begin
          lex_d     = LxQuot;
          qsingle_d = 1'b1;
        end else if (s1_byte_q == ChSlash) begin
          lex_d = LxSlash;
        end
      end
      LxEndTag: begin
        if (s1_byte_q == ChGt) begin
          lex_d  = LxText;
          nest_d = nest_dec;
        end
      end
      LxSlash: begin
        lex_d = (s1_byte_q == ChGt) ? LxText : LxTag;
      end
      LxCmt: begin
        if (s1_byte_q == ChDash) lex_d = LxCmtD1;
      end
      LxCmtD1: begin
        lex_d = (s1_byte_q == ChDash) ? LxCmtD2 : LxCmt;
      end
      LxCmtD2: begin
        lex_d = (s1_byte_q == ChGt) ? LxText : LxCmt;
      end
      LxPi: begin
        if (s1_byte_q == ChQmark) lex_d = LxPiQ;
      end
      LxPiQ: begin
        lex_d = (s1_byte_q == ChGt) ? LxText : LxPi;
      end
      LxQuot: begin
        if (s1_byte_q == qch)           lex_d = LxTag;
        else if (s1_byte_q == ChBslash) lex_d = LxQesc;
      end
      LxQesc: begin
        lex_d = LxQuot;
      end
      default: begin
        lex_d = LxText;
      end
    endcase
  end

  // Marks for the current byte
  always_comb begin
    smark_d = 1'b0;
    emark_d = 1'b0;
    fault_d = 1'b0;
    case (lex_q)
      LxText: begin
        smark_d = (s1_byte_q == ChLt) && cur_eq;
      end
      LxTag: begin
        fault_d = (s1_byte_q == ChGt) && (nest_q >= NestMax);
      end
      LxEndTag: begin
        // closing tag at level zero saturates and still tests for an end
        fault_d = (s1_byte_q == ChGt) && (nest_q == '0);
        emark_d = (s1_byte_q == ChGt) && dec_eq;
      end
      LxSlash: begin
        emark_d = (s1_byte_q == ChGt) && cur_eq;
      end
      default: begin
        smark_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_q       <= LxText;
      nest_q      <= '0;
      qsingle_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        lex_q     <= lex_d;
        nest_q    <= nest_d;
        qsingle_q <= qsingle_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q <= s1_byte_q;
      smark_q    <= smark_d;
      emark_q    <= emark_d;
      fault_q    <= fault_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_out_o    = out_byte_q;
  assign start_mark_o  = smark_q;
  assign end_mark_o    = emark_q;
  assign depth_fault_o = fault_q;

endmodule

`default_nettype wire

FILE: rtl/xes_checker.sv
// ----------------------------------------------------------------------------
// XML element splitter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "xml_element_splitter_unit_defines.svh"

module xes_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [xes_pkg::ByteW-1:0] byte_out_o,
  input wire logic                      start_mark_o,
  input wire logic                      end_mark_o,
  input wire logic                      depth_fault_o
);
  import xes_pkg::*;

  // hold a stalled transaction
  `XES_ASSERT_NX(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(byte_out_o), "stalled result changed")
  `XES_ASSERT(a_start_lt, out_valid_o && start_mark_o, byte_out_o == ChLt, "start mark not on a '<'")
  `XES_ASSERT(a_end_gt, out_valid_o && end_mark_o, byte_out_o == ChGt, "end mark not on a '>'")
  `XES_ASSERT(a_fault_gt, out_valid_o && depth_fault_o, byte_out_o == ChGt, "depth fault not on a '>'")
  `XES_ASSERT(a_start_end, out_valid_o, !(start_mark_o && end_mark_o), "start and end on one byte")

endmodule

bind xml_element_splitter_unit xes_checker u_xes_checker (.*);

`default_nettype wire
